// ===== design/b64d_pkg.sv =====
// shared types, constants and the character-to-sextet map for the base64 stream decoder
// no dependencies

package b64d_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_LENGTH = 2'd1;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd2;

    localparam logic [1:0] GROUP_THIRD = 2'd2;
    localparam logic [1:0] GROUP_FOURTH = 2'd3;

    typedef struct packed {
        logic       bad;
        logic [5:0] value;
    } sextet_t;

    // one decoded group handed from the front to the back
    typedef struct packed {
        logic [23:0] triple;
        logic [1:0]  count;
        logic        last;
        logic [1:0]  status;
    } group_cmd_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t    s;
        logic [7:0] d;
        s.bad = 1'b0;
        s.value = 6'd0;
        d = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
            s.value = d[5:0];
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h61 + 8'd26;
            s.value = d[5:0];
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd52;
            s.value = d[5:0];
        end else if (c == 8'h2B) begin
            s.value = 6'd62;
        end else if (c == 8'h2F) begin
            s.value = 6'd63;
        end else if (c == PAD_CHAR) begin
            s.value = 6'd0;
        end else begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

endpackage

// ===== design/base64_stream_decoder_unit.sv =====
// base64 stream decoder: one character word in per cycle while not stalled, decoded byte words out
// each group passes through the group queue into the back end's output register
// 1 character per cycle in, 1 byte per cycle out, each while not stalled; a 4-entry
// group queue decouples the sides, and in_stall rises only when that queue is full
// reset (rst_n low, asynchronous) clears group state, the queue and the output stage
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back

module base64_stream_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic [1:0] out_status
);

    logic                 push;
    logic                 pop;
    logic                 queue_full;
    logic                 queue_empty;
    b64d_pkg::group_cmd_t push_cmd;
    b64d_pkg::group_cmd_t head_cmd;

    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_char    (in_char),
        .in_last    (in_last),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    b64d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    b64d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .out_last    (out_last),
        .out_status  (out_status)
    );

endmodule

// ===== design/b64d_front.sv =====
// front end: accepts characters, maps them to sextets and assembles groups of four
// depends on b64d_pkg; pushes group commands into b64d_queue

module b64d_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             in_char,
    input  logic                   in_last,
    input  logic                   queue_full,
    output logic                   push,
    output b64d_pkg::group_cmd_t   push_cmd
);

    logic [17:0]       hold_reg, hold_next;
    logic [1:0]        pos_reg, pos_next;
    logic              third_pad_reg, third_pad_next;
    logic              bad_reg, bad_next;
    logic              accept;
    logic              bad_any;
    logic              pad_fourth;
    b64d_pkg::sextet_t sx;

    assign in_stall = queue_full;
    assign accept = in_valid & ~queue_full;

    always_comb
    begin
        hold_next = hold_reg;
        pos_next = pos_reg;
        third_pad_next = third_pad_reg;
        bad_next = bad_reg;
        push = 1'b0;
        push_cmd = '0;
        sx = b64d_pkg::sextet_of(in_char);
        bad_any = bad_reg | sx.bad;
        pad_fourth = in_last & (in_char == b64d_pkg::PAD_CHAR);
        if (accept)
        begin
            if (pos_reg != b64d_pkg::GROUP_FOURTH)
            begin
                if (in_last)
                begin
                    push = 1'b1;
                    push_cmd.triple = 24'd0;
                    push_cmd.count = 2'd1;
                    push_cmd.last = 1'b1;
                    push_cmd.status = b64d_pkg::STATUS_LENGTH;
                    hold_next = 18'd0;
                    pos_next = 2'd0;
                    third_pad_next = 1'b0;
                    bad_next = 1'b0;
                end
                else
                begin
                    hold_next = {hold_reg[11:0], sx.value};
                    pos_next = pos_reg + 2'd1;
                    if (pos_reg == b64d_pkg::GROUP_THIRD && in_char == b64d_pkg::PAD_CHAR)
                    begin
                        third_pad_next = 1'b1;
                    end
                    bad_next = bad_any;
                end
            end
            else
            begin
                push = 1'b1;
                push_cmd.triple = {hold_reg, sx.value};
                push_cmd.count = 2'd3 - {1'b0, pad_fourth}
                                 - {1'b0, in_last & third_pad_reg};
                push_cmd.last = in_last;
                push_cmd.status = bad_any ? b64d_pkg::STATUS_BAD_CHAR : b64d_pkg::STATUS_OK;
                hold_next = 18'd0;
                pos_next = 2'd0;
                third_pad_next = 1'b0;
                bad_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 18'd0;
            pos_reg <= 2'd0;
            third_pad_reg <= 1'b0;
            bad_reg <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
            pos_reg <= pos_next;
            third_pad_reg <= third_pad_next;
            bad_reg <= bad_next;
        end
    end

endmodule

// ===== design/b64d_queue.sv =====
// short queue of group commands between the front and back ends
// depends on b64d_pkg

module b64d_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  b64d_pkg::group_cmd_t   push_cmd,
    input  logic                   pop,
    output b64d_pkg::group_cmd_t   head_cmd,
    output logic                   full,
    output logic                   empty
);

    b64d_pkg::group_cmd_t              mem [b64d_pkg::QUEUE_DEPTH];
    logic [b64d_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [b64d_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [b64d_pkg::QUEUE_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                              do_push;
    logic                              do_pop;

    assign full = (cnt_reg == b64d_pkg::QUEUE_CNT_W'(b64d_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_push = push & ~full;
    assign do_pop = pop & ~empty;
    assign head_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + b64d_pkg::QUEUE_PTR_W'(do_push);
        rd_ptr_next = rd_ptr_reg + b64d_pkg::QUEUE_PTR_W'(do_pop);
        cnt_next = cnt_reg + b64d_pkg::QUEUE_CNT_W'(do_push)
                   - b64d_pkg::QUEUE_CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/b64d_back.sv =====
// back end: takes group commands from the queue and sends their bytes one word a cycle unless stalled
// depends on b64d_pkg; pops commands from b64d_queue

module b64d_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  b64d_pkg::group_cmd_t   head_cmd,
    input  logic                   queue_empty,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             out_byte,
    output logic                   out_last,
    output logic [1:0]             out_status
);

    b64d_pkg::group_cmd_t cur_reg, cur_next;
    logic [1:0]           idx_reg, idx_next;
    logic                 active_reg, active_next;
    logic                 at_end;
    logic                 can_load;

    assign at_end = (idx_reg == cur_reg.count - 2'd1);
    assign can_load = ~active_reg | (~out_stall & at_end);
    assign pop = can_load & ~queue_empty;

    always_comb
    begin
        cur_next = cur_reg;
        idx_next = idx_reg;
        active_next = active_reg;
        if (pop)
        begin
            cur_next = head_cmd;
            idx_next = 2'd0;
            active_next = 1'b1;
        end
        else if (can_load)
        begin
            active_next = 1'b0;
        end
        else if (~out_stall)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd0: out_byte = cur_reg.triple[23:16];
            2'd1: out_byte = cur_reg.triple[15:8];
            default: out_byte = cur_reg.triple[7:0];
        endcase
    end

    assign out_valid = active_reg;
    assign out_last = cur_reg.last & at_end;
    assign out_status = cur_reg.status;

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            active_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            active_reg <= active_next;
        end
    end

endmodule

// ===== design/b64d_checker.sv =====
// port-level checks for base64_stream_decoder_unit, attached with bind
// depends on b64d_pkg

module b64d_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       out_last,
    input logic [1:0] out_status
);

    // no status code beyond bad character
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status == b64d_pkg::STATUS_OK
                       || out_status == b64d_pkg::STATUS_LENGTH
                       || out_status == b64d_pkg::STATUS_BAD_CHAR))
        else $error("unknown status code on output");

    // length error is a single zero word that ends the stream
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status == b64d_pkg::STATUS_LENGTH) |-> (out_byte == 8'd0 && out_last))
        else $error("length error word malformed");

    // out_valid never rises straight out of reset
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid) && !$past(out_valid)) |-> $past(rst_n))
        else $error("output word appeared right out of reset");

    // stall toward the sender is always known while a word is offered
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown(in_stall))
        else $error("input stall unknown while a word is offered");

    // stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_byte)
                                      && $stable(out_last) && $stable(out_status)))
        else $error("stalled output word changed");

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_status (out_status)
);
